// ===== rtl/random_key_schedule_makespan_macros.svh =====
// Assertion macros used by the makespan evaluator checker.
`ifndef RANDOM_KEY_SCHEDULE_MAKESPAN_MACROS_SVH
`define RANDOM_KEY_SCHEDULE_MAKESPAN_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RKSM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rksm assertion failed");

// Next-cycle implication, disabled during reset.
`define RKSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rksm assertion failed");

`endif

// ===== rtl/rksm_pkg.sv =====
// Shared constants and the command type of the makespan evaluator.
package rksm_pkg;

   localparam int MACHINES     = 3;
   localparam int MACH_BITS    = 2;
   localparam int TIME_BITS    = 11;
   localparam int DUR_BITS     = TIME_BITS - 1;
   localparam int LOAD_BITS    = 16;
   localparam int TAG_BITS     = 7;
   localparam int KEY_BITS_DEF = 16;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

   typedef struct packed {
      logic [MACH_BITS-1:0] mach;
      logic [DUR_BITS-1:0]  dur;
      logic                 no_mach;
      logic                 last;
      logic [TAG_BITS-1:0]  tag;
   } cmd_type;

endpackage

// ===== rtl/rksm_front.sv =====
// Front end: eligibility, key decode and machine choice for one job.
module rksm_front #(
   parameter int KEY_BITS = rksm_pkg::KEY_BITS_DEF
) (
   input  logic [KEY_BITS-1:0]                  key,
   input  logic signed [rksm_pkg::TIME_BITS-1:0] times [rksm_pkg::MACHINES],
   input  logic                                 last_job,
   input  logic [rksm_pkg::TAG_BITS-1:0]        tag,
   output rksm_pkg::cmd_type                    cmd
);
   import rksm_pkg::*;

   localparam int PROD_BITS = KEY_BITS + MACH_BITS;

   logic [MACHINES-1:0]  elig;
   logic [MACH_BITS-1:0] n_elig;
   logic [PROD_BITS-1:0] prod;
   logic [MACH_BITS-1:0] k_sel;
   logic [MACH_BITS-1:0] rank;
   logic [MACH_BITS-1:0] mach;
   logic                 found;

   always_comb begin
      for (int i = 0; i < MACHINES; i++) begin
         elig[i] = ~times[i][TIME_BITS-1];
      end
      n_elig = MACH_BITS'($countones(elig));
      prod   = PROD_BITS'(key) * PROD_BITS'(n_elig);

      // k counts the slot boundaries that key*n lies strictly above
      k_sel = '0;
      for (int j = 1; j < MACHINES; j++) begin
         if ((MACH_BITS'(j) < n_elig) &&
             (prod > (PROD_BITS'(j) << KEY_BITS))) begin
            k_sel = k_sel + MACH_BITS'(1);
         end
      end

      // k-th eligible machine, counted from machine 0
      rank  = '0;
      mach  = '0;
      found = 1'b0;
      for (int i = 0; i < MACHINES; i++) begin
         if (elig[i]) begin
            if (!found && (rank == k_sel)) begin
               mach  = MACH_BITS'(i);
               found = 1'b1;
            end
            rank = rank + MACH_BITS'(1);
         end
      end

      cmd.mach    = mach;
      cmd.dur     = times[mach][DUR_BITS-1:0];
      cmd.no_mach = (n_elig == '0);
      cmd.last    = last_job;
      cmd.tag     = tag;
   end

endmodule

// ===== rtl/rksm_queue.sv =====
// Small FIFO of decoded commands between front and back end.
module rksm_queue #(
   parameter int DEPTH = rksm_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rksm_pkg::cmd_type push_cmd,
   output logic              can_push,
   input  logic              pop,
   output logic              head_valid,
   output rksm_pkg::cmd_type head_cmd
);
   import rksm_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   cmd_type             mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   assign can_push   = (count_ff != CNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/rksm_back.sv =====
// Back end: load update, saturation, makespan and the result register.
module rksm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   input  rksm_pkg::cmd_type                   cmd,
   output logic                                cmd_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rksm_pkg::MACH_BITS-1:0]      rsp_machine,
   output logic [rksm_pkg::LOAD_BITS-1:0]      rsp_start_time,
   output logic [rksm_pkg::LOAD_BITS-1:0]      rsp_finish_time,
   output logic [rksm_pkg::LOAD_BITS-1:0]      rsp_makespan,
   output logic                                rsp_done_res,
   output logic [rksm_pkg::TAG_BITS-1:0]       rsp_tag_out,
   output logic                                rsp_no_machine,
   output logic                                rsp_load_overflow
);
   import rksm_pkg::*;

   logic [LOAD_BITS-1:0] load_ff [MACHINES];
   logic [LOAD_BITS-1:0] load_in [MACHINES];
   logic [LOAD_BITS-1:0] load_upd [MACHINES];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MACH_BITS-1:0] mach_ff;
   logic [LOAD_BITS-1:0] start_ff, finish_ff, span_ff;
   logic                 done_ff, nomach_ff, ovf_ff;
   logic [TAG_BITS-1:0]  tag_ff;

   logic [LOAD_BITS-1:0] start_v;
   logic [LOAD_BITS:0]   sum_v;
   logic                 ovf_v;
   logic [LOAD_BITS-1:0] finish_v;
   logic [LOAD_BITS-1:0] span_v;

   assign cmd_pop = cmd_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      start_v  = cmd.no_mach ? '0 : load_ff[cmd.mach];
      sum_v    = {1'b0, start_v} + (LOAD_BITS + 1)'(cmd.dur);
      ovf_v    = !cmd.no_mach && sum_v[LOAD_BITS];
      finish_v = cmd.no_mach ? '0 : (ovf_v ? LOAD_MAX : sum_v[LOAD_BITS-1:0]);

      span_v = '0;
      for (int i = 0; i < MACHINES; i++) begin
         load_upd[i] = load_ff[i];
         if (!cmd.no_mach && (cmd.mach == MACH_BITS'(i))) begin
            load_upd[i] = finish_v;
         end
         if (load_upd[i] > span_v) begin
            span_v = load_upd[i];
         end
      end

      for (int i = 0; i < MACHINES; i++) begin
         load_in[i] = load_ff[i];
         if (cmd_pop) begin
            load_in[i] = cmd.last ? '0 : load_upd[i];
         end
      end

      rsp_valid_in = cmd_pop || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MACHINES; i++) begin
            load_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < MACHINES; i++) begin
            load_ff[i] <= load_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         mach_ff   <= cmd.no_mach ? '0 : cmd.mach;
         start_ff  <= start_v;
         finish_ff <= finish_v;
         span_ff   <= cmd.last ? span_v : '0;
         done_ff   <= cmd.last;
         tag_ff    <= cmd.tag;
         nomach_ff <= cmd.no_mach;
         ovf_ff    <= ovf_v;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_machine       = mach_ff;
   assign rsp_start_time    = start_ff;
   assign rsp_finish_time   = finish_ff;
   assign rsp_makespan      = span_ff;
   assign rsp_done_res      = done_ff;
   assign rsp_tag_out       = tag_ff;
   assign rsp_no_machine    = nomach_ff;
   assign rsp_load_overflow = ovf_ff;

endmodule

// ===== rtl/random_key_schedule_makespan.sv =====
// Random-key chromosome decoder: per-job machine choice and makespan, top level.
//
// Scores one chromosome of a genetic scheduler, one job per transaction. Each
// job carries a 0.KEY_BITS random key and a processing time per machine (a
// negative time marks the machine ineligible). The key picks the k-th of the
// n eligible machines, k being the smallest index with key*n <= (k+1)*2^KEY_BITS.
// The job time is added to that machine's load (saturating at 65535, flagged
// by rsp_load_overflow) and the result reports machine, start and finish. A
// job with no eligible machine sets rsp_no_machine and changes no load. On the
// last job the result also carries the makespan (largest load) and all loads
// are cleared for the next chromosome; rsp_makespan is 0 on other results.
// Rate: one transaction per cycle sustained while rsp_ready is high; an accepted
// job passes through the command queue and then the result register. The limit
// is the back end's load read / add / write loop. The front end decodes the key
// combinationally into a two-entry command queue, so input and output stall
// independently.
module random_key_schedule_makespan #(
   parameter int KEY_BITS    = rksm_pkg::KEY_BITS_DEF,
   parameter int QUEUE_DEPTH = rksm_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // job channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [KEY_BITS-1:0]                  req_key,
   input  logic signed [rksm_pkg::TIME_BITS-1:0] req_time_m0,
   input  logic signed [rksm_pkg::TIME_BITS-1:0] req_time_m1,
   input  logic signed [rksm_pkg::TIME_BITS-1:0] req_time_m2,
   input  logic                                 req_last_job,
   input  logic [rksm_pkg::TAG_BITS-1:0]        req_chromosome_tag,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rksm_pkg::MACH_BITS-1:0]       rsp_machine,
   output logic [rksm_pkg::LOAD_BITS-1:0]       rsp_start_time,
   output logic [rksm_pkg::LOAD_BITS-1:0]       rsp_finish_time,
   output logic [rksm_pkg::LOAD_BITS-1:0]       rsp_makespan,
   output logic                                 rsp_done_res,
   output logic [rksm_pkg::TAG_BITS-1:0]        rsp_tag_out,
   output logic                                 rsp_no_machine,
   output logic                                 rsp_load_overflow
);
   import rksm_pkg::*;

   logic signed [TIME_BITS-1:0] req_times [MACHINES];
   cmd_type                     front_cmd;
   cmd_type                     head_cmd;
   logic                        q_can_push;
   logic                        q_head_valid;
   logic                        q_pop;
   logic                        req_take;

   assign req_times[0] = req_time_m0;
   assign req_times[1] = req_time_m1;
   assign req_times[2] = req_time_m2;

   // accept whenever the command queue has room
   assign req_ready = q_can_push;
   assign req_take  = req_valid && q_can_push;

   rksm_front #(
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .key      (req_key),
      .times    (req_times),
      .last_job (req_last_job),
      .tag      (req_chromosome_tag),
      .cmd      (front_cmd)
   );

   rksm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_take),
      .push_cmd   (front_cmd),
      .can_push   (q_can_push),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (head_cmd)
   );

   // back end owns the loads and the result register
   rksm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (q_head_valid),
      .cmd               (head_cmd),
      .cmd_pop           (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_machine       (rsp_machine),
      .rsp_start_time    (rsp_start_time),
      .rsp_finish_time   (rsp_finish_time),
      .rsp_makespan      (rsp_makespan),
      .rsp_done_res      (rsp_done_res),
      .rsp_tag_out       (rsp_tag_out),
      .rsp_no_machine    (rsp_no_machine),
      .rsp_load_overflow (rsp_load_overflow)
   );

endmodule

// ===== rtl/rksm_checker.sv =====
// Port-level checker for the makespan evaluator, bound to the top level.
`include "random_key_schedule_makespan_macros.svh"

module rksm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rksm_pkg::MACH_BITS-1:0] rsp_machine,
   input logic [rksm_pkg::LOAD_BITS-1:0] rsp_start_time,
   input logic [rksm_pkg::LOAD_BITS-1:0] rsp_finish_time,
   input logic [rksm_pkg::LOAD_BITS-1:0] rsp_makespan,
   input logic                           rsp_done_res,
   input logic                           rsp_no_machine,
   input logic                           rsp_load_overflow
);
   import rksm_pkg::*;

   `RKSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_finish_time) && $stable(rsp_makespan))
   `RKSM_ASSERT_NOW(a_nomach_zero, clock, reset, rsp_valid && rsp_no_machine, (rsp_machine == '0) && (rsp_start_time == '0) && (rsp_finish_time == '0) && !rsp_load_overflow)
   `RKSM_ASSERT_NOW(a_span_only_done, clock, reset, rsp_valid && !rsp_done_res, rsp_makespan == '0)
   `RKSM_ASSERT_NOW(a_finish_order, clock, reset, rsp_valid && !rsp_no_machine, (rsp_finish_time >= rsp_start_time) && (!rsp_load_overflow || (rsp_finish_time == LOAD_MAX)))
   `RKSM_ASSERT_NOW(a_span_covers, clock, reset, rsp_valid && rsp_done_res && !rsp_no_machine, rsp_makespan >= rsp_finish_time)

endmodule

bind random_key_schedule_makespan rksm_checker u_rksm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_machine       (rsp_machine),
   .rsp_start_time    (rsp_start_time),
   .rsp_finish_time   (rsp_finish_time),
   .rsp_makespan      (rsp_makespan),
   .rsp_done_res      (rsp_done_res),
   .rsp_no_machine    (rsp_no_machine),
   .rsp_load_overflow (rsp_load_overflow)
);
